@@ rtl/time_window_weighted_average_unit_defines.svh @@
// Assertion macros for the weighted average unit.
`ifndef TIME_WINDOW_WEIGHTED_AVERAGE_UNIT_DEFINES_SVH
`define TIME_WINDOW_WEIGHTED_AVERAGE_UNIT_DEFINES_SVH
`ifndef ASSERT_OFF
`define ASSERT_IMPLIES(label, clk, rst_n, a, c) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
        else $error("assertion failed");
`define ASSERT_NEXT(label, clk, rst_n, a, c) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
        else $error("assertion failed");
`else
`define ASSERT_IMPLIES(label, clk, rst_n, a, c)
`define ASSERT_NEXT(label, clk, rst_n, a, c)
`endif
`endif

@@ rtl/twwa_pkg.sv @@
// ----------------------------------------------------------------------------
// twwa_pkg
// Shared types and constants of the time window weighted average unit.
// ----------------------------------------------------------------------------
package twwa_pkg;
    localparam int DEPTH = 64;
    localparam int AW = $clog2(DEPTH);
    localparam int CW = AW + 1;
    localparam int WSUM_W = 33 + AW + 1;
    localparam int WTSUM_W = 16 + AW + 1;
    localparam logic [16:0] ONE_Q16 = 17'd65536;

    localparam logic [1:0] REG_WINDOW = 2'd0;
    localparam logic [1:0] REG_HIGH = 2'd1;
    localparam logic [1:0] REG_LOW = 2'd2;

    localparam logic [1:0] LEVEL_NONE = 2'd0;
    localparam logic [1:0] LEVEL_HOLD = 2'd1;
    localparam logic [1:0] LEVEL_DETECT = 2'd2;

    typedef struct packed {
        logic [16:0] value;
        logic [15:0] weight;
        logic [31:0] tstamp;
    } entry_t;

    // request from the sequencer to the divider
    typedef struct packed {
        logic                 start;
        logic [WSUM_W-1:0]    num;
        logic [WTSUM_W-1:0]   den;
    } div_req_t;

    typedef struct packed {
        logic        done;
        logic [16:0] quot;
    } div_rsp_t;
endpackage

@@ rtl/twwa_if.sv @@
// ----------------------------------------------------------------------------
// twwa_in_if / twwa_out_if / twwa_cfg_if
// Valid/ready channels of the weighted average unit.
// ----------------------------------------------------------------------------
interface twwa_in_if;
    logic        valid;
    logic        ready;
    logic [16:0] feature_value;
    logic [15:0] feature_weight;
    logic [31:0] time_seconds;
    modport source (output valid, feature_value, feature_weight, time_seconds,
                    input ready);
    modport sink (input valid, feature_value, feature_weight, time_seconds,
                  output ready);
endinterface

interface twwa_out_if;
    logic        valid;
    logic        ready;
    logic [16:0] mean_value;
    logic [6:0]  kept_count;
    logic [1:0]  level;
    modport source (output valid, mean_value, kept_count, level, input ready);
    modport sink (input valid, mean_value, kept_count, level, output ready);
endinterface

interface twwa_cfg_if;
    logic        valid;
    logic        ready;
    logic [1:0]  index;
    logic [16:0] data;
    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

@@ rtl/twwa_ram.sv @@
// ----------------------------------------------------------------------------
// twwa_ram
// Entry ring memory: one write port, one registered read port.
// ----------------------------------------------------------------------------
module twwa_ram
    import twwa_pkg::*;
(
    input  logic          clk,
    input  logic          we,
    input  logic [AW-1:0] waddr,
    input  entry_t        wdata,
    input  logic [AW-1:0] raddr,
    output entry_t        rdata
);
    entry_t mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

@@ rtl/twwa_div.sv @@
// ----------------------------------------------------------------------------
// twwa_div
// Restoring divider, one quotient bit per cycle, quotient saturated to 1.0.
// ----------------------------------------------------------------------------
module twwa_div
    import twwa_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  div_req_t req,
    output div_rsp_t rsp
);
    localparam int QB = 18;
    localparam int RW = WTSUM_W + 1;

    logic [WSUM_W-1:0]  num_reg, num_next;
    logic [WTSUM_W-1:0] den_reg, den_next;
    logic [RW-1:0]      rem_reg, rem_next;
    logic [QB-1:0]      q_reg, q_next;
    logic [5:0]         cnt_reg, cnt_next;
    logic               busy_reg, busy_next;
    logic               done_reg, done_next;
    logic [RW-1:0]      trial;

    // quotient < 2^18 since num < 2^17 * den; start shifting at bit QB-1
    always_comb
    begin
        num_next = num_reg;
        den_next = den_reg;
        rem_next = rem_reg;
        q_next = q_reg;
        cnt_next = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        trial = '0;
        if (req.start)
        begin
            num_next = req.num;
            den_next = req.den;
            rem_next = RW'(req.num >> QB);
            q_next = '0;
            cnt_next = 6'(QB);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            trial = {rem_reg[RW-2:0], num_reg[cnt_reg[4:0] - 5'd1]};
            if (trial >= {1'b0, den_reg})
            begin
                rem_next = trial - {1'b0, den_reg};
                q_next = {q_reg[QB-2:0], 1'b1};
            end
            else
            begin
                rem_next = trial;
                q_next = {q_reg[QB-2:0], 1'b0};
            end
            cnt_next = cnt_reg - 6'd1;
            if (cnt_reg == 6'd1)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        num_reg <= num_next;
        den_reg <= den_next;
        rem_reg <= rem_next;
        q_reg <= q_next;
    end

    always_comb
    begin
        rsp.done = done_reg;
        if (den_reg == '0)
        begin
            rsp.quot = '0;
        end
        else if (q_reg > QB'(ONE_Q16))
        begin
            rsp.quot = ONE_Q16;
        end
        else
        begin
            rsp.quot = q_reg[16:0];
        end
    end
endmodule

@@ rtl/time_window_weighted_average_unit.sv @@
// ----------------------------------------------------------------------------
// time_window_weighted_average_unit
// Sliding time window weighted mean with a three level hysteresis decision.
// ----------------------------------------------------------------------------
// Channel   Dir  Payload
// in_ch     in   feature_value, feature_weight, time_seconds
// out_ch    out  mean_value, kept_count, level
// cfg_ch    in   index, data
//
// One item at a time: accept, read, check, append, compare, divide and output;
// the check is skipped with an empty ring. Each expired entry adds another
// ring memory read and check.
// Reset empties the ring by count; the memories are not cleared.
// The output register holds a result until it is taken; the next item is
// accepted in the cycle after it is taken.
`include "time_window_weighted_average_unit_defines.svh"
module time_window_weighted_average_unit
    import twwa_pkg::*;
(
    input logic clk,
    input logic rst_n,
    twwa_in_if.sink    in_ch,
    twwa_out_if.source out_ch,
    twwa_cfg_if.sink   cfg_ch
);
    typedef enum logic [6:0] {
        S_IDLE  = 7'b0000001,
        S_READ  = 7'b0000010,
        S_CHECK = 7'b0000100,
        S_APPND = 7'b0001000,
        S_CMP   = 7'b0010000,
        S_DIV   = 7'b0100000,
        S_OUT   = 7'b1000000
    } state_t;

    state_t state_reg, state_next;

    logic [7:0]  window_reg;
    logic [16:0] high_reg;
    logic [16:0] low_reg;

    logic [AW-1:0]      head_reg, head_next;
    logic [CW-1:0]      count_reg, count_next;
    logic [WSUM_W-1:0]  wsum_reg, wsum_next;
    logic [WTSUM_W-1:0] wtsum_reg, wtsum_next;
    logic               latch_reg, latch_next;

    entry_t      item_reg, item_next;
    logic [WSUM_W-1:0] hprod_reg, lprod_reg;
    logic [16:0] mean_reg, mean_next;
    logic [6:0]  kept_reg, kept_next;
    logic [1:0]  level_reg, level_next;

    logic          ram_we;
    logic [AW-1:0] ram_waddr, ram_raddr;
    entry_t        ram_rdata;
    div_req_t      dreq;
    div_rsp_t      drsp;
    logic [AW-1:0] tail;
    logic [32:0]   age;
    logic [32:0]   prod_drop;

    twwa_ram u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (item_reg),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    twwa_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (dreq),
        .rsp   (drsp)
    );

    // configuration writes
    assign cfg_ch.ready = 1'b1;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            window_reg <= 8'd1;
            high_reg <= 17'd32768;
            low_reg <= 17'd13107;
        end
        else if (cfg_ch.valid)
        begin
            unique case (cfg_ch.index)
                REG_WINDOW: window_reg <= cfg_ch.data[7:0];
                REG_HIGH:   high_reg <= cfg_ch.data;
                REG_LOW:    low_reg <= cfg_ch.data;
                default:    ;
            endcase
        end
    end

    assign in_ch.ready = (state_reg == S_IDLE);
    assign out_ch.valid = (state_reg == S_OUT);
    assign out_ch.mean_value = mean_reg;
    assign out_ch.kept_count = kept_reg;
    assign out_ch.level = level_reg;

    assign tail = head_reg + count_reg[AW-1:0];
    assign age = {1'b0, item_reg.tstamp} - {1'b0, ram_rdata.tstamp};
    assign prod_drop = 33'(ram_rdata.value) * 33'(ram_rdata.weight);
    assign ram_raddr = head_reg;
    assign ram_we = (state_reg == S_APPND);
    assign ram_waddr = (count_reg == CW'(DEPTH)) ? head_reg : tail;

    // sequencer: expiry walk, append, compare, divide
    always_comb
    begin
        state_next = state_reg;
        head_next = head_reg;
        count_next = count_reg;
        wsum_next = wsum_reg;
        wtsum_next = wtsum_reg;
        latch_next = latch_reg;
        item_next = item_reg;
        mean_next = mean_reg;
        kept_next = kept_reg;
        level_next = level_reg;
        dreq.start = 1'b0;
        dreq.num = wsum_reg;
        dreq.den = wtsum_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_ch.valid)
                begin
                    item_next.value = (in_ch.feature_value > ONE_Q16) ? ONE_Q16
                                                                     : in_ch.feature_value;
                    item_next.weight = in_ch.feature_weight;
                    item_next.tstamp = in_ch.time_seconds;
                    state_next = S_READ;
                end
            end
            S_READ:
            begin
                state_next = (count_reg == '0) ? S_APPND : S_CHECK;
            end
            S_CHECK:
            begin
                // age is positive only when the stored time is older
                if (!age[32] && age != '0 && age[31:0] > {24'd0, window_reg})
                begin
                    wsum_next = wsum_reg - WSUM_W'(prod_drop);
                    wtsum_next = wtsum_reg - WTSUM_W'(ram_rdata.weight);
                    head_next = head_reg + AW'(1);
                    count_next = count_reg - CW'(1);
                    state_next = S_READ;
                end
                else
                begin
                    state_next = S_APPND;
                end
            end
            S_APPND:
            begin
                // ring full: overwrite the oldest entry; its data is in rdata
                if (count_reg == CW'(DEPTH))
                begin
                    wsum_next = wsum_reg - WSUM_W'(prod_drop)
                              + WSUM_W'(item_reg.value) * WSUM_W'(item_reg.weight);
                    wtsum_next = wtsum_reg - WTSUM_W'(ram_rdata.weight)
                               + WTSUM_W'(item_reg.weight);
                    head_next = head_reg + AW'(1);
                end
                else
                begin
                    wsum_next = wsum_reg
                              + WSUM_W'(item_reg.value) * WSUM_W'(item_reg.weight);
                    wtsum_next = wtsum_reg + WTSUM_W'(item_reg.weight);
                    count_next = count_reg + CW'(1);
                end
                state_next = S_CMP;
            end
            S_CMP:
            begin
                dreq.start = 1'b1;
                kept_next = 7'(count_reg);
                if (wtsum_reg != '0 && wsum_reg > hprod_reg)
                begin
                    latch_next = 1'b1;
                    level_next = LEVEL_DETECT;
                end
                else if (wtsum_reg != '0 && latch_reg && wsum_reg > lprod_reg)
                begin
                    level_next = LEVEL_HOLD;
                end
                else
                begin
                    latch_next = 1'b0;
                    level_next = LEVEL_NONE;
                end
                state_next = S_DIV;
            end
            S_DIV:
            begin
                if (drsp.done)
                begin
                    mean_next = drsp.quot;
                    state_next = S_OUT;
                end
            end
            S_OUT:
            begin
                if (out_ch.ready)
                begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    // threshold products, registered after the sums settle (17 x 23 bits)
    always_ff @(posedge clk)
    begin
        hprod_reg <= WSUM_W'(high_reg) * WSUM_W'(wtsum_next);
        lprod_reg <= WSUM_W'(low_reg) * WSUM_W'(wtsum_next);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            head_reg <= '0;
            count_reg <= '0;
            wsum_reg <= '0;
            wtsum_reg <= '0;
            latch_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            head_reg <= head_next;
            count_reg <= count_next;
            wsum_reg <= wsum_next;
            wtsum_reg <= wtsum_next;
            latch_reg <= latch_next;
        end
    end

    always_ff @(posedge clk)
    begin
        item_reg <= item_next;
        mean_reg <= mean_next;
        kept_reg <= kept_next;
        level_reg <= level_next;
    end

    `ASSERT_IMPLIES(a_count_range, clk, rst_n, 1'b1, count_reg <= CW'(DEPTH))
    `ASSERT_IMPLIES(a_level_latch, clk, rst_n, out_ch.valid && out_ch.level != LEVEL_NONE, latch_reg)
    `ASSERT_NEXT(a_out_hold, clk, rst_n, out_ch.valid && !out_ch.ready, out_ch.valid && $stable(out_ch.mean_value))
    `ASSERT_IMPLIES(a_kept_nonzero, clk, rst_n, out_ch.valid, out_ch.kept_count != 7'd0)
endmodule
